[rtl/orbit_camera_position_assert.svh]
// assertion helpers for the orbit camera block
`ifndef ORBIT_CAMERA_POSITION_ASSERT_SVH
`define ORBIT_CAMERA_POSITION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OCP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("orbit camera check failed");

// next-cycle implication, checked out of reset
`define OCP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("orbit camera check failed");

`endif

[rtl/orbcam_pkg.sv]
`timescale 1ns / 1ps
package orbcam_pkg;

  // cordic datapath width, multiplier operand widths
  localparam int CW    = 33;
  localparam int MA_W  = 26;
  localparam int PW    = MA_W + CW;
  localparam int MAX_CORDIC_STEPS = 24;

  // 0.607253 in Q30, start vector of the rotation
  localparam logic signed [CW-1:0] CORDIC_K = 33'sd652032874;

  // configuration register indexes
  localparam logic [7:0] REG_RADIUS    = 8'd0;
  localparam logic [7:0] REG_ELEVATION = 8'd1;
  localparam logic [7:0] REG_GAIN      = 8'd2;
  localparam logic [7:0] REG_MAX_STEP  = 8'd3;

  // atan(2^-i) on a 32 bit full turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/orbit_camera_position.sv]
`timescale 1ns / 1ps
// Orbit camera: one input transfer per frame carries a horizontal mouse
// delta and an optional look target. The block turns its stored azimuth by
// the scaled and clamped delta, then returns the eye position
// target + radius * (sin(el)cos(az), cos(el), sin(el)sin(az)) and the new
// azimuth as one output transfer. Both channels use valid/ready; the
// configuration channel writes radius, elevation, gain and max step by
// index and is always ready (write it only while the block is idle).
// One shared CORDIC stage runs sine/cosine for elevation then azimuth, one
// step per cycle, and one shared multiplier does the turn product and the
// four radius products. in_ready_o is high only in the idle state, so the
// block takes no new item before the last one leaves its last step. The
// result sits in an output register: the next item is taken while it
// waits, and a finished item holds in its last step until the output
// register frees. Reset sets azimuth to a quarter turn, clears the stored
// target and loads the default register values.
module orbit_camera_position
  import orbcam_pkg::*;
#(
  parameter int PHASE_BITS      = 16,
  parameter int COORD_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [11:0] mouse_dx_i,
  input  logic               target_valid_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] eye_x_o,
  output logic signed [31:0] eye_y_o,
  output logic signed [31:0] eye_z_o,
  output logic [15:0]        azimuth_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam longint unsigned FULL = 64'd1 << PHASE_BITS;
  localparam logic [23:0] RST_RADIUS = 24'(64'd850 << COORD_FRAC_BITS);
  localparam logic [15:0] RST_ELEV   = 16'(((7 * FULL + 18) / 36) & (FULL - 1));
  localparam logic [11:0] RST_GAIN   = 12'((FULL * 1000 + 314159) / 628319);
  localparam logic [14:0] RST_STEP   = 15'((FULL * 40000 + 3141592) / 6283185);
  localparam logic [PHASE_BITS-1:0] RST_AZ = PHASE_BITS'(FULL >> 2);

  typedef enum logic [3:0] {
    S_IDLE, S_TURN, S_AZ, S_COR_EL, S_COR_AZ,
    S_MUL_RS, S_MUL_RC, S_MUL_CA, S_MUL_SA, S_EYE_Z, S_FINISH
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [23:0] radius_q;
  logic [15:0] elev_q;
  logic [11:0] gain_q;
  logic [14:0] step_q;

  // persistent state
  logic [PHASE_BITS-1:0] az_q;
  logic signed [31:0]    tgt_x_q, tgt_y_q, tgt_z_q;

  // work registers
  logic signed [11:0]   dx_q;
  logic signed [PW-1:0] prod_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic                 flip_q;
  logic [ITER_W-1:0]    iter_q;
  logic signed [CW-1:0] se_q, ce_q, sa_q, ca_q;
  logic signed [MA_W-1:0] rs_q;
  logic signed [31:0]   ex_q, ey_q, ez_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
  logic [15:0]        azimuth_q;

  logic in_xfer, out_xfer, cfg_xfer, cor_last, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cor_last    = (iter_q == ITER_W'(CORDIC_STEPS - 1));

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [CW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TURN: begin
        mul_a = MA_W'(dx_q);
        mul_b = $signed({21'd0, gain_q});
      end
      S_MUL_RS: begin
        mul_a = $signed({2'b00, radius_q});
        mul_b = se_q;
      end
      S_MUL_RC: begin
        mul_a = $signed({2'b00, radius_q});
        mul_b = ce_q;
      end
      S_MUL_CA: begin
        mul_a = rs_q;
        mul_b = ca_q;
      end
      S_MUL_SA: begin
        mul_a = rs_q;
        mul_b = sa_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // round to nearest on dropping 30 fraction bits
  logic signed [PW-1:0] rnd_w;
  logic signed [32:0]   rnd33;
  assign rnd_w = (prod_q + PW'(64'sd536870912)) >>> 30;
  assign rnd33 = rnd_w[32:0];

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] t,
                                                 input logic signed [32:0] r);
    logic signed [33:0] s;
    s = 34'(t) + 34'(r);
    if (s > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // turn clamp and azimuth update
  logic signed [PW-1:0] step_w;
  logic signed [16:0]   turn_d;
  logic signed [31:0]   turn_ext;
  logic [PHASE_BITS-1:0] az_d;

  assign step_w = $signed({{(PW - 15){1'b0}}, step_q});

  always_comb begin
    if (prod_q > step_w) begin
      turn_d = $signed({2'b00, step_q});
    end else if (prod_q < -step_w) begin
      turn_d = -$signed({2'b00, step_q});
    end else begin
      turn_d = prod_q[16:0];
    end
  end

  assign turn_ext = 32'(turn_d);
  assign az_d     = az_q - turn_ext[PHASE_BITS-1:0];

  // cordic start from a phase: fold the half turns beyond a quarter turn
  logic [PHASE_BITS+15:0] el_wide;
  logic [PHASE_BITS-1:0]  init_phase;
  logic [31:0]            ang, ang_f;
  logic                   init_flip;

  assign el_wide    = {{PHASE_BITS{1'b0}}, elev_q};
  assign init_phase = (state_q == S_AZ) ? el_wide[PHASE_BITS-1:0] : az_q;
  assign ang        = {init_phase, {(32 - PHASE_BITS){1'b0}}};
  assign init_flip  = ang[31] ^ ang[30];
  assign ang_f      = {ang[31] ^ init_flip, ang[30:0]};

  // one cordic rotation step
  logic signed [CW-1:0] x_sh, y_sh, x_nx, y_nx, z_nx, atan_v, s_fin, c_fin;
  logic                 dir_pos;

  assign x_sh    = x_q >>> iter_q;
  assign y_sh    = y_q >>> iter_q;
  assign atan_v  = $signed({1'b0, atan_lut(5'(iter_q))});
  assign dir_pos = !z_q[CW-1];
  assign x_nx    = dir_pos ? x_q - y_sh : x_q + y_sh;
  assign y_nx    = dir_pos ? y_q + x_sh : y_q - x_sh;
  assign z_nx    = dir_pos ? z_q - atan_v : z_q + atan_v;
  assign s_fin   = flip_q ? -y_nx : y_nx;
  assign c_fin   = flip_q ? -x_nx : x_nx;

  logic [PHASE_BITS+15:0] az_wide;
  assign az_wide = {16'd0, az_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_TURN;
      S_TURN:   state_d = S_AZ;
      S_AZ:     state_d = S_COR_EL;
      S_COR_EL: if (cor_last) state_d = S_COR_AZ;
      S_COR_AZ: if (cor_last) state_d = S_MUL_RS;
      S_MUL_RS: state_d = S_MUL_RC;
      S_MUL_RC: state_d = S_MUL_CA;
      S_MUL_CA: state_d = S_MUL_SA;
      S_MUL_SA: state_d = S_EYE_Z;
      S_EYE_Z:  state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= RST_RADIUS;
      elev_q      <= RST_ELEV;
      gain_q      <= RST_GAIN;
      step_q      <= RST_STEP;
      az_q        <= RST_AZ;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      tgt_z_q     <= '0;
      dx_q        <= '0;
      prod_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      flip_q      <= 1'b0;
      iter_q      <= '0;
      se_q        <= '0;
      ce_q        <= '0;
      sa_q        <= '0;
      ca_q        <= '0;
      rs_q        <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      ez_q        <= '0;
      out_valid_q <= 1'b0;
      eye_x_q     <= '0;
      eye_y_q     <= '0;
      eye_z_q     <= '0;
      azimuth_q   <= '0;
    end else begin
      state_q <= state_d;
      prod_q  <= mul_p;

      if (cfg_xfer) begin
        case (cfg_index_i)
          REG_RADIUS:    radius_q <= cfg_data_i;
          REG_ELEVATION: elev_q   <= cfg_data_i[15:0];
          REG_GAIN:      gain_q   <= cfg_data_i[11:0];
          REG_MAX_STEP:  step_q   <= cfg_data_i[14:0];
          default: ;
        endcase
      end

      if (in_xfer) begin
        dx_q <= mouse_dx_i;
        if (target_valid_i) begin
          tgt_x_q <= target_x_i;
          tgt_y_q <= target_y_i;
          tgt_z_q <= target_z_i;
        end
      end

      // a new result may load in the same cycle the old one transfers
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_AZ: begin
          az_q   <= az_d;
          x_q    <= CORDIC_K;
          y_q    <= '0;
          z_q    <= CW'($signed(ang_f));
          flip_q <= init_flip;
          iter_q <= '0;
        end
        S_COR_EL, S_COR_AZ: begin
          if (cor_last) begin
            if (state_q == S_COR_EL) begin
              se_q <= s_fin;
              ce_q <= c_fin;
            end else begin
              sa_q <= s_fin;
              ca_q <= c_fin;
            end
            // azimuth rotation starts right after elevation
            x_q    <= CORDIC_K;
            y_q    <= '0;
            z_q    <= CW'($signed(ang_f));
            flip_q <= init_flip;
            iter_q <= '0;
          end else begin
            x_q    <= x_nx;
            y_q    <= y_nx;
            z_q    <= z_nx;
            iter_q <= iter_q + 1'b1;
          end
        end
        S_MUL_RC: rs_q <= rnd_w[MA_W-1:0];
        S_MUL_CA: ey_q <= sat_add(tgt_y_q, rnd33);
        S_MUL_SA: ex_q <= sat_add(tgt_x_q, rnd33);
        S_EYE_Z:  ez_q <= sat_add(tgt_z_q, rnd33);
        S_FINISH: begin
          if (out_free) begin
            eye_x_q     <= ex_q;
            eye_y_q     <= ey_q;
            eye_z_q     <= ez_q;
            azimuth_q   <= az_wide[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign eye_x_o     = eye_x_q;
  assign eye_y_o     = eye_y_q;
  assign eye_z_o     = eye_z_q;
  assign azimuth_o   = azimuth_q;

  `include "orbit_camera_position_assert.svh"

  `OCP_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `OCP_ASSERT_IMP(a_iter_range, state_q == S_COR_EL || state_q == S_COR_AZ, iter_q <= ITER_W'(CORDIC_STEPS - 1))
  `OCP_ASSERT_NXT(a_az_hold_idle, state_q == S_IDLE, $stable(az_q))
  `OCP_ASSERT_NXT(a_finish_waits, state_q == S_FINISH && out_valid_q && !out_ready_i, state_q == S_FINISH && out_valid_q)

endmodule

[test/orbit_camera_position_tb.sv]
`timescale 1ns / 1ps
module orbit_camera_position_tb;
  import orbcam_pkg::*;

  localparam int  LATENCY     = 2 * 16 + 8;
  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  NUM_PHASES  = 8;
  localparam int  PHASE_ITEMS = 205;
  localparam int  NUM_ROWS    = 15;

  // indexes with no register behind them
  localparam logic [7:0] REG_NONE_LO = 8'd4;
  localparam logic [7:0] REG_NONE_HI = 8'd255;

  // which fields of a directed row carry a typed-in expectation
  localparam logic [3:0] PIN_X  = 4'b0001;
  localparam logic [3:0] PIN_Y  = 4'b0010;
  localparam logic [3:0] PIN_Z  = 4'b0100;
  localparam logic [3:0] PIN_AZ = 4'b1000;

  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  localparam longint ROT_START_Q30 = 652032874;
  localparam longint ATAN_TURN32 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef struct packed {
    logic signed [11:0] dx;
    logic               tv;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } frame_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        az;
  } eye_t;

  typedef struct packed {
    frame_t     fr;
    logic [3:0] pin;
    eye_t       want;
  } dir_row_t;

  // default registers: gain 104, turn limit 417, azimuth starts at 16384
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{'{12'sh000, 1'b1, 32'h0, 32'h0, 32'h0}, PIN_AZ, '{32'h0, 32'h0, 32'h0, 16'd16384}},
    '{'{12'sh7ff, 1'b0, 32'h0, 32'h0, 32'h0}, PIN_AZ, '{32'h0, 32'h0, 32'h0, 16'd15967}},
    '{'{12'sh800, 1'b0, 32'h0, 32'h0, 32'h0}, PIN_AZ, '{32'h0, 32'h0, 32'h0, 16'd16384}},
    '{'{12'sh001, 1'b0, 32'h0, 32'h0, 32'h0}, PIN_AZ, '{32'h0, 32'h0, 32'h0, 16'd16280}},
    '{'{12'shfff, 1'b0, 32'h0, 32'h0, 32'h0}, PIN_AZ, '{32'h0, 32'h0, 32'h0, 16'd16384}},
    '{'{12'sh000, 1'b1, POS_MAX, POS_MAX, POS_MAX}, PIN_Y | PIN_Z | PIN_AZ,
      '{32'h0, POS_MAX, POS_MAX, 16'd16384}},
    // target ignored: saturated eye stays
    '{'{12'sh000, 1'b0, NEG_MAX, NEG_MAX, NEG_MAX}, PIN_Y | PIN_Z | PIN_AZ,
      '{32'h0, POS_MAX, POS_MAX, 16'd16384}},
    '{'{12'sh004, 1'b0, 32'h0, 32'h0, 32'h0}, PIN_Y | PIN_Z | PIN_AZ,
      '{32'h0, POS_MAX, POS_MAX, 16'd15968}},
    '{'{12'shffc, 1'b1, NEG_MAX, NEG_MAX, NEG_MAX}, PIN_AZ, '{32'h0, 32'h0, 32'h0, 16'd16384}},
    '{'{12'sh000, 1'b0, 32'h0, 32'h0, 32'h0}, 4'b0, '0},
    '{'{12'sh555, 1'b1, 32'h1234_5678, 32'hedcb_a988, 32'h0000_0100}, 4'b0, '0},
    '{'{12'shaaa, 1'b1, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f}, 4'b0, '0},
    '{'{12'sh003, 1'b0, 32'hffff_ffff, 32'h0, 32'h0}, 4'b0, '0},
    '{'{12'sh800, 1'b1, 32'h0, 32'h0, 32'h0}, 4'b0, '0},
    '{'{12'sh000, 1'b1, NEG_MAX, POS_MAX, 32'h0000_0001}, 4'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [11:0] mouse_dx_i;
  logic               target_valid_i;
  logic signed [31:0] target_x_i;
  logic signed [31:0] target_y_i;
  logic signed [31:0] target_z_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] eye_x_o;
  logic signed [31:0] eye_y_o;
  logic signed [31:0] eye_z_o;
  logic [15:0]        azimuth_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [7:0]         cfg_index_i;
  logic [23:0]        cfg_data_i;

  // predictor state
  logic [23:0] cur_radius;
  logic [15:0] cur_elev;
  logic [11:0] cur_gain;
  logic [14:0] cur_max_step;
  logic [15:0] model_az;
  longint      look_pos [3];

  eye_t pending_eyes [$];
  eye_t eye_head;
  int   fail_count      = 0;
  int   frames_sent     = 0;
  int   eyes_checked    = 0;
  int   settings_used   = 0;
  int   cycle_count     = 0;
  int   rx_cycle        = 0;
  int   rx_hold         = 0;

  orbit_camera_position uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mouse_dx_i     (mouse_dx_i),
    .target_valid_i (target_valid_i),
    .target_x_i     (target_x_i),
    .target_y_i     (target_y_i),
    .target_z_i     (target_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .eye_x_o        (eye_x_o),
    .eye_y_o        (eye_y_o),
    .eye_z_o        (eye_z_o),
    .azimuth_o      (azimuth_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // rotation-mode cordic, phase folded by a half turn outside +-90 degrees
  function automatic void sincos(input logic [15:0] ph, output longint s, output longint c);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, nx;
    a = {ph, 16'h0000};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = $signed(a);
    x = ROT_START_Q30;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURN32[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURN32[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  // product dropping 30 fraction bits, halves rounded up
  function automatic longint q30_round(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return POS_MAX;
    if (v < -64'sd2147483648) return NEG_MAX;
    return v[31:0];
  endfunction

  function automatic eye_t predict_eye(input frame_t f);
    longint dxl, g, lim, turn, rad, se, ce, sa, ca, rs;
    eye_t   e;
    if (f.tv) begin
      look_pos[0] = f.tx;
      look_pos[1] = f.ty;
      look_pos[2] = f.tz;
    end
    dxl  = f.dx;
    g    = cur_gain;
    lim  = cur_max_step;
    turn = dxl * g;
    if (turn > lim) turn = lim;
    if (turn < -lim) turn = -lim;
    model_az = model_az - turn[15:0];
    sincos(cur_elev, se, ce);
    sincos(model_az, sa, ca);
    rad  = cur_radius;
    rs   = q30_round(rad, se);
    e.x  = sat32(look_pos[0] + q30_round(rs, ca));
    e.y  = sat32(look_pos[1] + q30_round(rad, ce));
    e.z  = sat32(look_pos[2] + q30_round(rs, sa));
    e.az = model_az;
    return e;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return POS_MAX;
      1: return NEG_MAX;
      2: return $urandom_range(0, 131071) - 65536;
      default: return $urandom();
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    case ($urandom_range(0, 3))
      0: f.dx = 12'($urandom_range(0, 12) - 6);
      1: begin
        case ($urandom_range(0, 3))
          0: f.dx = 12'sh7ff;
          1: f.dx = 12'sh800;
          2: f.dx = 12'sh001;
          default: f.dx = 12'shfff;
        endcase
      end
      default: f.dx = 12'($urandom());
    endcase
    f.tv = ($urandom_range(0, 2) != 0);
    f.tx = rand_coord();
    f.ty = rand_coord();
    f.tz = rand_coord();
    return f;
  endfunction

  // leaves in_valid_i high; the caller lowers it when a gap follows
  task automatic send_frame(input frame_t f, input logic [3:0] pin, input eye_t fixed);
    eye_t e;
    in_valid_i     <= 1'b1;
    mouse_dx_i     <= f.dx;
    target_valid_i <= f.tv;
    target_x_i     <= f.tx;
    target_y_i     <= f.ty;
    target_z_i     <= f.tz;
    do @(posedge clk_i); while (!in_ready_o);
    e = predict_eye(f);
    if (pin & PIN_X) e.x = fixed.x;
    if (pin & PIN_Y) e.y = fixed.y;
    if (pin & PIN_Z) e.z = fixed.z;
    if (pin & PIN_AZ) e.az = fixed.az;
    pending_eyes.push_back(e);
    frames_sent++;
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RADIUS:    cur_radius   = data;
      REG_ELEVATION: cur_elev     = data[15:0];
      REG_GAIN:      cur_gain     = data[11:0];
      REG_MAX_STEP:  cur_max_step = data[14:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_eyes.size() != 0) @(posedge clk_i);
  endtask

  // receiver: always ready, coin flips, one-in-eight, and long stalls
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_cycle[11:10])
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= ($urandom_range(0, 1) == 0);
        2'd2: out_ready_i <= (rx_cycle[2:0] == 3'd5);
        default: begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(1, 60);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_eyes.size() == 0) begin
        $error("eye position with no frame waiting: x %0d y %0d z %0d az %0d",
               eye_x_o, eye_y_o, eye_z_o, azimuth_o);
        fail_count++;
      end else begin
        eye_head = pending_eyes.pop_front();
        eyes_checked++;
        if (eye_x_o !== eye_head.x) begin
          $error("eye_x: expected %0d, got %0d", eye_head.x, eye_x_o);
          fail_count++;
        end
        if (eye_y_o !== eye_head.y) begin
          $error("eye_y: expected %0d, got %0d", eye_head.y, eye_y_o);
          fail_count++;
        end
        if (eye_z_o !== eye_head.z) begin
          $error("eye_z: expected %0d, got %0d", eye_head.z, eye_z_o);
          fail_count++;
        end
        if (azimuth_o !== eye_head.az) begin
          $error("azimuth: expected %0d, got %0d", eye_head.az, azimuth_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim
    int          sent, burst, gap;
    logic        paused, pause_now;
    logic [23:0] r, el, g, st;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    mouse_dx_i     <= '0;
    target_valid_i <= 1'b0;
    target_x_i     <= '0;
    target_y_i     <= '0;
    target_z_i     <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    cur_radius   = 24'd217600;
    cur_elev     = 16'd12743;
    cur_gain     = 12'd104;
    cur_max_step = 15'd417;
    model_az     = 16'd16384;
    look_pos[0]  = 0;
    look_pos[1]  = 0;
    look_pos[2]  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++)
      send_frame(DIRECTED[i].fr, DIRECTED[i].pin, DIRECTED[i].want);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin r = 24'd217600;  el = 24'd12743;   g = 24'd104;   st = 24'd417;    end
        1: begin r = 24'hffffff;  el = 24'h004000;  g = 24'hfff;   st = 24'h7fff;   end
        2: begin r = 24'h000000;  el = 24'h000000;  g = 24'h000;   st = 24'h0000;   end
        // zero turn limit with gain, upper data bits above each width set
        3: begin r = 24'hffffff;  el = 24'ha5ffff;  g = 24'hfff001; st = 24'hff8000; end
        4: begin r = 24'd217600;  el = 24'h008000;  g = 24'hfff;   st = 24'h0001;   end
        default: begin
          r  = 24'($urandom());
          el = 24'($urandom());
          g  = 24'($urandom());
          st = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 2000)) : 24'($urandom());
        end
      endcase
      cfg_write(REG_RADIUS, r);
      cfg_write(REG_NONE_LO, 24'($urandom()));
      cfg_write(REG_ELEVATION, el);
      cfg_write(REG_GAIN, g);
      cfg_write(REG_NONE_HI, 24'($urandom()));
      cfg_write(REG_MAX_STEP, st);
      cfg_valid_i <= 1'b0;
      settings_used++;

      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          send_frame(rand_frame(), 4'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        // once per setting the sender holds off until the block has drained
        pause_now = !paused && (sent >= PHASE_ITEMS / 2);
        if (gap != 0 || pause_now) begin
          in_valid_i <= 1'b0;
          if (pause_now) begin
            paused = 1'b1;
            wait_drained();
          end
          repeat (gap) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (pending_eyes.size() != 0) begin
      $error("%0d eye positions never arrived", pending_eyes.size());
      fail_count++;
    end
    $display("tb: %0d frames sent, %0d eye positions checked", frames_sent, eyes_checked);
    $display("tb: %0d register settings, zero and full-scale radius, gain and turn limit",
             settings_used);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/orbcam_pkg.sv
rtl/orbit_camera_position.sv
test/orbit_camera_position_tb.sv
